### rtl/dspiru_pkg.sv
// Package for the DSP instruction register-use decoder.
// Holds format codes, flag bit constants, mask types and the ALU op use table.
// No dependencies.
package dspiru_pkg;

  localparam int INSTR_W = 64;
  localparam int MASK_W  = 32;
  localparam int FLAG_W  = 14;
  localparam int OUT_W   = 80;  // 32 + 32 + 14, padded to whole bytes

  // Instruction field positions
  localparam int FMT_LSB   = 61;
  localparam int SEL_BIT   = 41;
  localparam int ALU_LSB   = 42;
  localparam int MUL_LSB   = 27;
  localparam int ALU_FLD_W = 19;
  localparam int MUL_FLD_W = 15;
  localparam int ONE_FLD_W = 14;

  typedef enum logic [2:0] {
    FMT_DUAL0   = 3'd0,
    FMT_DUAL1   = 3'd1,
    FMT_DUAL2   = 3'd2,
    FMT_RSVD3   = 3'd3,
    FMT_SINGLE4 = 3'd4,
    FMT_SINGLE5 = 3'd5,
    FMT_SINGLE6 = 3'd6,
    FMT_RSVD7   = 3'd7
  } fmt_t;

  // Flag bits
  localparam logic [FLAG_W-1:0] F_AZ = 14'h0001;
  localparam logic [FLAG_W-1:0] F_AN = 14'h0002;
  localparam logic [FLAG_W-1:0] F_AV = 14'h0004;
  localparam logic [FLAG_W-1:0] F_AU = 14'h0008;
  localparam logic [FLAG_W-1:0] F_AD = 14'h0010;
  localparam logic [FLAG_W-1:0] F_ZC = 14'h0020;
  localparam logic [FLAG_W-1:0] F_IL = 14'h0040;
  localparam logic [FLAG_W-1:0] F_NR = 14'h0080;
  localparam logic [FLAG_W-1:0] F_ZD = 14'h0100;
  localparam logic [FLAG_W-1:0] F_MN = 14'h0200;
  localparam logic [FLAG_W-1:0] F_MZ = 14'h0400;
  localparam logic [FLAG_W-1:0] F_MV = 14'h0800;
  localparam logic [FLAG_W-1:0] F_MU = 14'h1000;
  localparam logic [FLAG_W-1:0] F_MD = 14'h2000;

  localparam logic [FLAG_W-1:0] F_MUL  = F_MN | F_MZ | F_MV;
  localparam logic [FLAG_W-1:0] F_FMUL = F_MN | F_MZ | F_MV | F_MU | F_MD;

  // Operand use: {read i1, read i2, write io}
  localparam logic [2:0] USE_NONE = 3'b000;
  localparam logic [2:0] USE_12O  = 3'b111;
  localparam logic [2:0] USE_12   = 3'b110;
  localparam logic [2:0] USE_1O   = 3'b101;

  typedef struct packed {
    logic              rd_i1;
    logic              rd_i2;
    logic              wr_io;
    logic [FLAG_W-1:0] flags;
  } alu_use_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flag;
    logic [MASK_W-1:0] dst;
    logic [MASK_W-1:0] src;
  } masks_t;

  function automatic alu_use_t alu_use(input logic [4:0] op);
    logic [2:0]        u;
    logic [FLAG_W-1:0] f;
    alu_use_t          r;
    u = USE_NONE;
    f = '0;
    case (op)
      5'd0:                u = USE_12O;
      default:             u = USE_NONE;
    endcase
    case (op) inside
      5'd0, 5'd24, 5'd25, 5'd26: begin
        u = USE_12O; f = F_AN | F_AZ | F_AV | F_AU;
      end
      5'd1, 5'd3: begin
        u = USE_12O; f = F_ZC | F_AN | F_AZ | F_AV | F_AU | F_AD;
      end
      5'd2: begin
        u = USE_12O; f = F_AN | F_AZ | F_AV | F_AU | F_AD;
      end
      5'd4: begin
        u = USE_12; f = F_AN | F_AZ | F_AV | F_AU | F_AD;
      end
      5'd5: begin
        u = USE_1O; f = F_AN | F_AZ | F_AD;
      end
      5'd6: begin
        u = USE_12O; f = F_AN | F_AZ | F_AU | F_AD;
      end
      5'd7: begin
        u = USE_NONE; f = '0;
      end
      5'd8, 5'd14: begin
        u = USE_1O; f = F_AN | F_AZ | F_AV | F_AD;
      end
      5'd9: begin
        u = USE_1O; f = F_AN | F_AZ | F_AU | F_AD;
      end
      5'd10: begin
        u = USE_1O; f = F_ZD | F_AN | F_AZ | F_AU | F_AD;
      end
      5'd11: begin
        u = USE_1O; f = F_NR | F_AN | F_AZ | F_AU | F_AD;
      end
      5'd12: begin
        u = USE_1O; f = F_IL | F_AN | F_AZ | F_AD;
      end
      5'd13, 5'd30, 5'd31: begin
        u = USE_1O; f = F_AN | F_AZ;
      end
      5'd15: begin
        u = USE_1O; f = F_AN | F_AZ | F_AV | F_AD | F_AU;
      end
      5'd16, 5'd18: begin
        u = USE_12O; f = F_AN | F_AZ | F_AV;
      end
      5'd17, 5'd19: begin
        u = USE_12O; f = F_ZC | F_AN | F_AZ | F_AV;
      end
      5'd20: begin
        u = USE_12; f = F_AN | F_AZ | F_AV;
      end
      5'd21: begin
        u = USE_1O; f = F_AN | F_AZ | F_AV;
      end
      5'd22: begin
        u = USE_1O; f = '0;
      end
      5'd23: begin
        u = USE_1O; f = F_ZC;
      end
      5'd27, 5'd28, 5'd29: begin
        u = USE_1O; f = F_AN | F_AZ | F_AV | F_AU;
      end
      default: begin
        u = USE_NONE; f = '0;
      end
    endcase
    {r.rd_i1, r.rd_i2, r.wr_io} = u;
    r.flags = f;
    return r;
  endfunction

endpackage

### rtl/dspiru_decode.sv
// Combinational register-use decode of one instruction word into three masks.
// Depends on dspiru_pkg.
module dspiru_decode (
  input  logic [dspiru_pkg::INSTR_W-1:0] instr,
  output dspiru_pkg::masks_t             masks
);
  import dspiru_pkg::*;

  // Source code to mask bit; codes 16-31 name no tracked register
  function automatic logic [MASK_W-1:0] src_bit(input logic [4:0] code, input logic mul_side);
    logic [MASK_W-1:0] v;
    v = '0;
    if (!code[4]) v[{mul_side, code[3:0]}] = 1'b1;
    return v;
  endfunction

  // Destination code: 0-7 MA, 8-15 MB, 16-23 AA, 24-31 AB
  function automatic logic [MASK_W-1:0] dst_bit(input logic [4:0] code);
    logic [MASK_W-1:0] v;
    v = '0;
    v[{~code[4], code[3:0]}] = 1'b1;
    return v;
  endfunction

  fmt_t                 fmt;
  logic [ALU_FLD_W-1:0] alu_f;
  logic [MUL_FLD_W-1:0] mul_f;
  logic [ONE_FLD_W-1:0] one_f;
  logic                 sel_alu;
  alu_use_t             au;

  // ALU side contribution
  logic [MASK_W-1:0]    alu_src, alu_dst;
  logic [FLAG_W-1:0]    alu_flag;
  // Multiplier side contribution
  logic [MUL_FLD_W-1:0] mfld;
  logic [MASK_W-1:0]    mul_src, mul_dst;
  logic [FLAG_W-1:0]    mul_flag;
  logic                 use_alu, use_mul;

  assign fmt     = fmt_t'(instr[FMT_LSB +: 3]);
  assign alu_f   = instr[ALU_LSB +: ALU_FLD_W];
  assign mul_f   = instr[MUL_LSB +: MUL_FLD_W];
  assign one_f   = instr[ALU_LSB +: ONE_FLD_W];
  assign sel_alu = instr[SEL_BIT];
  assign au      = alu_use(alu_f[18:14]);

  always_comb begin
    alu_src  = '0;
    alu_dst  = '0;
    if (au.rd_i1) alu_src = alu_src | src_bit({1'b0, alu_f[13:10]}, 1'b0);
    if (au.rd_i2) alu_src = alu_src | src_bit(alu_f[9:5], 1'b0);
    if (au.wr_io) alu_dst = dst_bit(alu_f[4:0]);
    alu_flag = au.flags;
  end

  always_comb begin
    use_alu = 1'b0;
    use_mul = 1'b0;
    mfld    = mul_f;
    unique case (fmt) inside
      FMT_DUAL0, FMT_DUAL1, FMT_DUAL2: begin
        use_alu = 1'b1;
        use_mul = 1'b1;
      end
      FMT_SINGLE4, FMT_SINGLE5, FMT_SINGLE6: begin
        use_alu = sel_alu;
        use_mul = !sel_alu;
        mfld    = {1'b0, one_f};
      end
      default: begin
        use_alu = 1'b0;
        use_mul = 1'b0;
      end
    endcase
  end

  always_comb begin
    mul_src  = src_bit({1'b0, mfld[13:10]}, 1'b1) | src_bit(mfld[9:5], 1'b1);
    mul_dst  = dst_bit(mfld[4:0]);
    mul_flag = mfld[14] ? F_FMUL : F_MUL;
  end

  always_comb begin
    masks.src  = (use_alu ? alu_src  : '0) | (use_mul ? mul_src  : '0);
    masks.dst  = (use_alu ? alu_dst  : '0) | (use_mul ? mul_dst  : '0);
    masks.flag = (use_alu ? alu_flag : '0) | (use_mul ? mul_flag : '0);
  end

endmodule

### rtl/dsp_instruction_register_use_decode.sv
// DSP instruction register-use decoder, top level. Depends on dspiru_pkg, dspiru_decode.
// Pipeline: input register, then result register. Throughput: one instruction per cycle
// while out_tready is high; decode is one combinational pass between the two registers,
// and the input register refills while a held result waits for out_tready.
// Reset: rst_n synchronous, active low; clears both valid flags, data registers are not reset.
module dsp_instruction_register_use_decode (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: instr_word [63:0]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dspiru_pkg::INSTR_W-1:0] in_tdata,
  // out_tdata: src_mask [31:0], dst_mask [63:32], flag_mask [77:64], zero [79:78]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dspiru_pkg::OUT_W-1:0]   out_tdata
);
  import dspiru_pkg::*;

  logic               s1_valid_r, s1_valid_nxt;
  logic [INSTR_W-1:0] s1_data_r;
  logic               out_valid_r, out_valid_nxt;
  masks_t             out_masks_r;
  masks_t             dec_masks;
  logic               s1_adv;
  logic               in_xfer;

  // Result register can take a new word when empty or being drained this cycle
  assign s1_adv    = !out_valid_r || out_tready;
  // Input register frees up when its word moves on to the result register
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  dspiru_decode u_decode (
    .instr (s1_data_r),
    .masks (dec_masks)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) out_valid_nxt = s1_valid_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: capture on transfer, advance decoded masks when the result slot opens
  always_ff @(posedge clk) begin
    if (in_xfer) s1_data_r <= in_tdata;
    if (s1_adv && s1_valid_r) out_masks_r <= dec_masks;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_masks_r.flag, out_masks_r.dst, out_masks_r.src};

endmodule
